// ===== rtl/core/largest_empty_square_finder_assert.svh =====
// Assertion macros used by the largest empty square finder RTL.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LESF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lesf: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LESF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lesf: next-cycle check failed");

`endif

// ===== rtl/core/lesf_pkg.sv =====
// Package with sizes, register indexes and shared types of the square finder.
package lesf_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;

    localparam int ROW_W  = 10;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int SIDE_W = 11;
    localparam int SIZE_W = 11;
    localparam int CHAR_W = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_CHAR = 2'd2;

    localparam logic [SIZE_W-1:0] NUM_ROWS_RESET = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] NUM_COLS_RESET = SIZE_W'(1024);

    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [SIDE_W-1:0] data;
    } line_wr_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/lesf_if.sv =====
// Handshake interfaces for the cell, result and configuration channels.
interface lesf_cell_if;
    import lesf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface lesf_result_if;
    import lesf_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [ROW_W-1:0]  top_row;
    logic [COL_W-1:0]  left_col;
    logic [SIDE_W-1:0] side;

    modport source (output valid, output found, output top_row, output left_col,
                    output side, input ready);
    modport sink   (input valid, input found, input top_row, input left_col,
                    input side, output ready);
endinterface

interface lesf_cfg_if;
    import lesf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/largest_empty_square_finder.sv =====
// Largest empty square finder: accepts one grid cell per cycle in raster order
// when the input is not stalled, and reports the largest obstacle-free square once
// the last cell of a grid is in. Each cell reads its column of the side line
// memory when it is accepted and writes the new side back when it commits from the
// back stage register, where the registered read data of that memory is used.
// The result of a grid is held in an output register once its last cell commits
// from the back stage register; input stalls only when a grid ends while the
// previous result has not yet been taken. No clearing pass is needed after reset.
`include "largest_empty_square_finder_assert.svh"

module largest_empty_square_finder (
    input  logic          clk,
    input  logic          rst_n,
    lesf_cfg_if.sink      cfg,
    lesf_cell_if.sink     cell_in,
    lesf_result_if.source result_out
);
    import lesf_pkg::*;

    logic [SIZE_W-1:0] num_rows_reg;
    logic [SIZE_W-1:0] num_cols_reg;
    logic [CHAR_W-1:0] obstacle_reg;
    logic [SIZE_W-1:0] rows_lim;
    logic [SIZE_W-1:0] cols_lim;

    logic [COL_W-1:0]  col_count_reg;
    logic [COL_W-1:0]  col_count_next;
    logic [ROW_W-1:0]  row_count_reg;
    logic [ROW_W-1:0]  row_count_next;
    logic              col_end;
    logic              row_end;
    logic              in_acc;

    logic              b_valid_reg;
    logic [COL_W-1:0]  b_col_reg;
    logic [ROW_W-1:0]  b_row_reg;
    logic              b_first_row_reg;
    logic              b_obst_reg;
    logic              b_eol_reg;
    logic              b_last_reg;
    logic              b_commit;

    logic [SIDE_W-1:0] left_reg;
    logic [SIDE_W-1:0] diag_reg;
    logic [SIDE_W-1:0] best_side_reg;
    logic [ROW_W-1:0]  best_row_reg;
    logic [COL_W-1:0]  best_col_reg;

    logic [SIDE_W-1:0] line_up;
    logic [SIDE_W-1:0] up;
    logic [SIDE_W-1:0] least;
    logic [SIDE_W-1:0] v;
    logic              better;
    logic [SIDE_W-1:0] cand_side;
    logic [ROW_W-1:0]  cand_row;
    logic [COL_W-1:0]  cand_col;
    logic [SIDE_W-1:0] top_wide;
    logic [SIDE_W-1:0] left_wide;

    logic              res_valid_reg;
    logic              res_found_reg;
    logic [ROW_W-1:0]  res_top_reg;
    logic [COL_W-1:0]  res_left_reg;
    logic [SIDE_W-1:0] res_side_reg;

    line_wr_t          line_wr;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= NUM_ROWS_RESET;
            num_cols_reg <= NUM_COLS_RESET;
            obstacle_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_NUM_ROWS:      num_rows_reg <= cfg.data;
                CFG_NUM_COLS:      num_cols_reg <= cfg.data;
                CFG_OBSTACLE_CHAR: obstacle_reg <= cfg.data[CHAR_W-1:0];
                default:           ;
            endcase
        end
    end

    assign rows_lim = clamp_size(num_rows_reg, SIZE_W'(MAX_ROWS));
    assign cols_lim = clamp_size(num_cols_reg, SIZE_W'(MAX_COLS));

    // Front: raster position of the incoming cell and launch of the line read.
    assign b_commit      = b_valid_reg && (!b_last_reg || !res_valid_reg || result_out.ready);
    assign cell_in.ready = !b_valid_reg || b_commit;
    assign in_acc        = cell_in.valid && cell_in.ready;

    assign col_end = (SIZE_W'(col_count_reg) + SIZE_W'(1)) >= cols_lim;
    assign row_end = (SIZE_W'(row_count_reg) + SIZE_W'(1)) >= rows_lim;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_acc)
        begin
            if (!col_end)
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
            else
            begin
                col_count_next = '0;
                row_count_next = row_end ? '0 : row_count_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (in_acc)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_commit)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            b_col_reg       <= col_count_reg;
            b_row_reg       <= row_count_reg;
            b_first_row_reg <= (row_count_reg == '0);
            b_obst_reg      <= (cell_in.cell_value == obstacle_reg);
            b_eol_reg       <= col_end;
            b_last_reg      <= col_end && row_end;
        end
    end

    // Back: side of the square ending at this cell, write-back and best tracking.
    lesf_line_mem u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (col_count_reg),
        .wr      (line_wr),
        .rd_data (line_up)
    );

    assign up = b_first_row_reg ? '0 : line_up;

    always_comb
    begin
        least = (up < left_reg) ? up : left_reg;
        if (diag_reg < least)
        begin
            least = diag_reg;
        end
        v = b_obst_reg ? '0 : least + SIDE_W'(1);
    end

    assign line_wr.en   = b_commit;
    assign line_wr.addr = b_col_reg;
    assign line_wr.data = v;

    assign better    = v > best_side_reg;
    assign cand_side = better ? v : best_side_reg;
    assign cand_row  = better ? b_row_reg : best_row_reg;
    assign cand_col  = better ? b_col_reg : best_col_reg;
    assign top_wide  = SIDE_W'(cand_row) + SIDE_W'(1) - cand_side;
    assign left_wide = SIDE_W'(cand_col) + SIDE_W'(1) - cand_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_side_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && result_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (b_commit)
            begin
                left_reg <= b_eol_reg ? '0 : v;
                diag_reg <= b_eol_reg ? '0 : up;
                if (b_last_reg)
                begin
                    best_side_reg <= '0;
                    best_row_reg  <= '0;
                    best_col_reg  <= '0;
                    res_valid_reg <= 1'b1;
                end
                else
                begin
                    best_side_reg <= cand_side;
                    best_row_reg  <= cand_row;
                    best_col_reg  <= cand_col;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_commit && b_last_reg)
        begin
            res_found_reg <= (cand_side != '0);
            res_top_reg   <= (cand_side != '0) ? top_wide[ROW_W-1:0] : '0;
            res_left_reg  <= (cand_side != '0) ? left_wide[COL_W-1:0] : '0;
            res_side_reg  <= cand_side;
        end
    end

    assign result_out.valid    = res_valid_reg;
    assign result_out.found    = res_found_reg;
    assign result_out.top_row  = res_top_reg;
    assign result_out.left_col = res_left_reg;
    assign result_out.side     = res_side_reg;

    `LESF_ASSERT_IMP(a_none_has_no_side, result_out.valid && !result_out.found, result_out.side == '0)
    `LESF_ASSERT_IMP(a_found_has_side, result_out.valid && result_out.found, result_out.side != '0)
    `LESF_ASSERT_IMP(a_stall_only_on_result, !cell_in.ready, b_valid_reg && b_last_reg && res_valid_reg)
    `LESF_ASSERT_NXT(a_stalled_cell_holds, b_valid_reg && !b_commit, b_valid_reg && $stable(b_col_reg))

endmodule

// ===== rtl/core/lesf_line_mem.sv =====
// Line memory of square sides with registered reads and write-to-read forwarding.
module lesf_line_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [lesf_pkg::COL_W-1:0]    rd_addr,
    input  lesf_pkg::line_wr_t            wr,
    output logic [lesf_pkg::SIDE_W-1:0]   rd_data
);
    import lesf_pkg::*;

    logic [SIDE_W-1:0] mem [MAX_COLS];
    logic [SIDE_W-1:0] mem_data_reg;
    logic [SIDE_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_data_reg <= mem[rd_addr];
            fwd_data_reg <= wr.data;
        end
    end

    // A read issued in the same cycle as a write to that entry takes the new value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_data_reg;

endmodule

// ===== tb/largest_empty_square_finder_checker.sv =====
// Checker that predicts each square result from the observed requests and compares it.
`timescale 1ns / 1ps
module largest_empty_square_finder_checker (
    input  logic        clk,
    input  logic        rst_n,
    lesf_cfg_if         cfg,
    lesf_cell_if        cell_in,
    lesf_result_if      result_out,
    output int unsigned mismatch_count,
    output int unsigned squares_pending
);
    import lesf_pkg::*;

    typedef struct packed {
        logic              found;
        logic [ROW_W-1:0]  top_row;
        logic [COL_W-1:0]  left_col;
        logic [SIDE_W-1:0] side;
    } square_t;

    logic [SIZE_W-1:0] rows_cfg;
    logic [SIZE_W-1:0] cols_cfg;
    logic [CHAR_W-1:0] obstacle_cfg;

    logic [SIDE_W-1:0] prev_row_sides [MAX_COLS];
    logic [SIDE_W-1:0] left_run;
    logic [SIDE_W-1:0] diag_run;
    logic [SIDE_W-1:0] best_len;
    logic [ROW_W-1:0]  row_at;
    logic [ROW_W-1:0]  best_row_end;
    logic [COL_W-1:0]  col_at;
    logic [COL_W-1:0]  best_col_end;

    square_t expected_squares [$];
    square_t want;

    function automatic int bounded(input logic [SIZE_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    task automatic clear_grid();
        left_run = '0;
        diag_run = '0;
        row_at = '0;
        col_at = '0;
        best_len = '0;
        best_row_end = '0;
        best_col_end = '0;
    endtask

    task automatic fold_cell(input logic [CHAR_W-1:0] cell_byte);
        logic [SIDE_W-1:0] above;
        logic [SIDE_W-1:0] least;
        logic [SIDE_W-1:0] here;
        square_t sq;
        above = (row_at != 0) ? prev_row_sides[col_at] : '0;
        least = (above < left_run) ? above : left_run;
        least = (least < diag_run) ? least : diag_run;
        here = (cell_byte == obstacle_cfg) ? '0 : least + 1'b1;
        prev_row_sides[col_at] = here;
        left_run = here;
        diag_run = above;
        if (here > best_len)
        begin
            best_len = here;
            best_row_end = row_at;
            best_col_end = col_at;
        end
        if (int'(col_at) + 1 < bounded(cols_cfg, MAX_COLS))
        begin
            col_at = col_at + 1'b1;
        end
        else
        begin
            col_at = '0;
            left_run = '0;
            diag_run = '0;
            if (int'(row_at) + 1 < bounded(rows_cfg, MAX_ROWS))
            begin
                row_at = row_at + 1'b1;
            end
            else
            begin
                sq = '0;
                if (best_len != 0)
                begin
                    sq.found = 1'b1;
                    sq.top_row = best_row_end + ROW_W'(1) - ROW_W'(best_len);
                    sq.left_col = best_col_end + COL_W'(1) - COL_W'(best_len);
                    sq.side = best_len;
                end
                expected_squares.push_back(sq);
                clear_grid();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg = NUM_ROWS_RESET;
            cols_cfg = NUM_COLS_RESET;
            obstacle_cfg = '0;
            clear_grid();
            expected_squares.delete();
            mismatch_count = 0;
            squares_pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_NUM_ROWS:      rows_cfg = cfg.data;
                    CFG_NUM_COLS:      cols_cfg = cfg.data;
                    CFG_OBSTACLE_CHAR: obstacle_cfg = cfg.data[CHAR_W-1:0];
                    default:           ;
                endcase
            end
            if (cell_in.valid && cell_in.ready)
                fold_cell(cell_in.cell_value);
            if (result_out.valid && result_out.ready)
            begin
                if (expected_squares.size() == 0)
                begin
                    mismatch_count++;
                    $error("result with no request outstanding");
                end
                else
                begin
                    want = expected_squares.pop_front();
                    if (result_out.found !== want.found)
                    begin
                        mismatch_count++;
                        $error("found: expected %0d, got %0d", want.found, result_out.found);
                    end
                    if (result_out.top_row !== want.top_row)
                    begin
                        mismatch_count++;
                        $error("top_row: expected %0d, got %0d", want.top_row,
                               result_out.top_row);
                    end
                    if (result_out.left_col !== want.left_col)
                    begin
                        mismatch_count++;
                        $error("left_col: expected %0d, got %0d", want.left_col,
                               result_out.left_col);
                    end
                    if (result_out.side !== want.side)
                    begin
                        mismatch_count++;
                        $error("side: expected %0d, got %0d", want.side, result_out.side);
                    end
                end
            end
            squares_pending = expected_squares.size();
        end
    end

endmodule

// ===== tb/largest_empty_square_finder_tb.sv =====
// Testbench top: drives grids and register writes into the square finder and gives the verdict.
`timescale 1ns / 1ps
module largest_empty_square_finder_tb;
    import lesf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 180;

    logic clk;
    logic rst_n;

    lesf_cfg_if    cfg_if ();
    lesf_cell_if   cell_if ();
    lesf_result_if result_if ();

    int unsigned mismatch_count;
    int unsigned squares_pending;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int idle_cycles;
    int rows_eff;
    int cols_eff;
    int at_row;
    int at_col;
    int items_sent;
    logic [CHAR_W-1:0] obstacle_now;

    largest_empty_square_finder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .cell_in    (cell_if),
        .result_out (result_if)
    );

    largest_empty_square_finder_checker square_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_if),
        .cell_in         (cell_if),
        .result_out      (result_if),
        .mismatch_count  (mismatch_count),
        .squares_pending (squares_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                result_if.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                result_if.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_if.valid && cfg_if.ready) || (cell_if.valid && cell_if.ready)
            || (result_if.valid && result_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no request moved for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int extent(input logic [CFG_DATA_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_cell(input int density);
        if ($urandom_range(99) < density)
            return obstacle_now;
        return CHAR_W'($urandom_range(255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_extent(input int hi);
        if ($urandom_range(11) == 0)
            return '0;
        return CFG_DATA_W'($urandom_range(1, hi));
    endfunction

    task automatic push_cell(input logic [CHAR_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cell_if.valid = 1'b0;
            @(negedge clk);
        end
        cell_if.valid = 1'b1;
        cell_if.cell_value = value;
        @(posedge clk);
        while (!cell_if.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (at_col + 1 < cols_eff)
        begin
            at_col++;
        end
        else
        begin
            at_col = 0;
            at_row = (at_row + 1 < rows_eff) ? at_row + 1 : 0;
        end
    endtask

    task automatic settle();
        cell_if.valid = 1'b0;
        while (squares_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid = 1'b0;
        case (idx)
            CFG_NUM_ROWS:      rows_eff = extent(data, MAX_ROWS);
            CFG_NUM_COLS:      cols_eff = extent(data, MAX_COLS);
            CFG_OBSTACLE_CHAR: obstacle_now = data[CHAR_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] cols,
                             input logic [CFG_DATA_W-1:0] obstacle);
        settle();
        write_reg(CFG_NUM_ROWS, rows);
        write_reg(CFG_NUM_COLS, cols);
        write_reg(CFG_OBSTACLE_CHAR, obstacle);
    endtask

    task automatic run_grid();
        int density;
        int split;
        int cells;
        int n;
        logic [CFG_DATA_W-1:0] obst_word;
        if ($urandom_range(2) == 0)
        begin
            obst_word = CFG_DATA_W'($urandom_range(2047));
            case ($urandom_range(3))
                0:       obst_word[CHAR_W-1:0] = '0;
                1:       obst_word[CHAR_W-1:0] = '1;
                default: ;
            endcase
            configure(pick_extent(6), pick_extent(8), obst_word);
        end
        case ($urandom_range(4))
            0:       density = 0;
            1:       density = 10;
            2:       density = 30;
            3:       density = 55;
            default: density = 85;
        endcase
        cells = rows_eff * cols_eff;
        split = (cells > 1 && $urandom_range(7) == 0) ? $urandom_range(1, cells - 1) : 0;
        n = 0;
        do
        begin
            push_cell(pick_cell(density));
            n++;
            if (n == split)
            begin
                // The line only holds valid sides up to the current width, so a
                // write in the middle of a grid never widens it.
                settle();
                case ($urandom_range(2))
                    0:       write_reg(CFG_NUM_ROWS, pick_extent(8));
                    1:       write_reg(CFG_NUM_COLS, CFG_DATA_W'($urandom_range(cols_eff)));
                    default: write_reg(CFG_OBSTACLE_CHAR, CFG_DATA_W'($urandom_range(255)));
                endcase
            end
        end
        while (at_row != 0 || at_col != 0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int target;
        target = items_sent + PHASE_ITEMS;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        while (items_sent < target)
            run_grid();
    endtask

    initial
    begin
        logic [CHAR_W-1:0] pair_grid [10];
        pair_grid = '{8'h01, 8'h02, 8'h00, 8'h04, 8'h08, 8'h10, 8'h20, 8'h00, 8'h40, 8'h80};
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_NUM_ROWS;
        cfg_if.data = '0;
        cell_if.valid = 1'b0;
        cell_if.cell_value = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        idle_cycles = 0;
        rows_eff = MAX_ROWS;
        cols_eff = MAX_COLS;
        obstacle_now = '0;
        at_row = 0;
        at_col = 0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(CFG_UNMAPPED, '1);

        // A grid made only of obstacles reports nothing found.
        configure(11'd1, 11'd2, 11'h7FF);
        push_cell(8'hFF);
        push_cell(8'hFF);

        // Zero sizes act as a single cell.
        configure(11'd0, 11'd0, 11'd0);
        push_cell(8'hFF);

        // Two equal squares side by side: the left one wins.
        configure(11'd2, 11'd5, 11'd0);
        foreach (pair_grid[k])
            push_cell(pair_grid[k]);

        // Narrow and shorten the grid and swap the obstacle byte part way through.
        configure(11'd3, 11'd4, 11'h055);
        push_cell(8'hAA);
        push_cell(8'h0F);
        push_cell(8'hF0);
        push_cell(8'h33);
        push_cell(8'hAA);
        settle();
        write_reg(CFG_NUM_COLS, 11'd2);
        write_reg(CFG_NUM_ROWS, 11'd2);
        write_reg(CFG_OBSTACLE_CHAR, 11'h0AA);
        push_cell(8'h55);

        // Oversized sizes do not end a grid early; smaller sizes written part
        // way through end the row and then the grid at the next boundary.
        configure(11'd2047, 11'd2047, 11'd0);
        repeat (5)
            push_cell(pick_cell(30));
        settle();
        write_reg(CFG_NUM_COLS, 11'd2);
        repeat (5)
            push_cell(pick_cell(30));
        settle();
        write_reg(CFG_NUM_ROWS, 11'd2);
        repeat (2)
            push_cell(pick_cell(30));

        // Hold the result channel while tiny grids keep coming, then drain.
        configure(11'd1, 11'd2, CFG_DATA_W'($urandom_range(255)));
        hold_request = HOLD_CYCLES;
        @(negedge clk);
        repeat (24)
            push_cell(pick_cell(30));
        settle();

        configure(11'd4, 11'd4, 11'd0);
        run_phase(0, 0);
        run_phase(56, 0);
        run_phase(0, 56);
        run_phase(19, 19);

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
